[sv/lsi_pkg.sv]
// Package: command codes, signature constants, CRC table and queue entry type.
package lsi_pkg;

  localparam int unsigned TableEntriesDef = 193;
  localparam logic [7:0]  ScanStartsRst   = 8'd200;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  localparam logic [31:0] Sig4A = 32'h0E0F1601;
  localparam logic [31:0] Sig4B = 32'h4E4F5641;
  localparam logic [39:0] Sig5C = 40'h0319020512;
  localparam logic [39:0] Sig5G = 40'h474F204157;
  localparam logic [39:0] Sig5S = 40'h534E414B45;
  localparam logic [5:0]  FamN  = 6'd22;
  localparam logic [5:0]  FamC  = 6'd47;
  localparam logic [5:0]  FamG  = 6'd12;
  localparam logic [5:0]  FamS  = 6'd48;

  localparam int unsigned RomLen = 193;
  localparam logic [31:0] RomCrc [RomLen] = '{
    32'h261DBA0E,32'h8AAE883E,32'h2EF78649,32'h03969E4B,32'hFCE154D8,
    32'hF9D0BE97,32'h5A1D548D,32'hCF2A7534,32'hA19943D0,32'h95094A3A,
    32'hF6EA5D74,32'h6C280859,32'hBBDC123F,32'hB3EDBE12,32'h15C61C29,
    32'hDE2C7D61,32'h4D7D872D,32'h2CC1E59C,32'h89D45404,32'hE493F1F9,
    32'hD5961DB0,
    32'hAD318CC4,32'h230936D6,32'h39B7A588,32'h2277F4DD,32'h4CF069E0,
    32'h3B4A219E,32'hAFD39E15,32'h9B898EF1,32'hAEAD5C1E,32'h8B5FA78A,
    32'h09A49BB4,32'h58583B59,32'hF33ED7A2,32'h4825AB54,32'h5DD93BE5,
    32'hEB752E5F,32'h1EB8DA0A,32'h2BF72881,32'h59142D65,32'h723AD943,
    32'hE24E270C,32'hCD8D92EE,
    32'h366784C8,
    32'hD09BF46F,32'h8D6E30E7,32'h88613263,32'h291E606A,32'h6EA1C3AD,
    32'hC618D67A,32'h657CC9CD,32'h554FAB46,32'h8D14D322,32'h7EBF1CC9,
    32'hCDEB4E81,32'h6B76D7C7,32'hDC5FABC2,32'hC949C625,32'h97AB5438,
    32'hFC8E7F96,32'h69D7FCC6,
    32'h00A517B5,32'h518F7B24,32'h3F6DD277,32'hD73E85F7,32'h548CC3DA,
    32'h834D852F,32'h6C791C31,32'h1BEBD222,32'h9DCF6B97,32'h81C86C4A,
    32'h7C1A7B45,32'h917CCAF0,32'h5FBA5BA7,32'h4C2A7C85,32'h70900492,
    32'h7BF88049,32'hDE86E455,32'hC6A33E82,32'hB50AB01A,32'h223890AF,
    32'hEA89FD1F,32'hB3AE738A,32'hE5869C31,32'hCBCCDB4E,32'hD0528E47,
    32'h25035DF8,32'h4FA62BEC,32'h266B6BD6,32'h17060B09,32'h32935096,
    32'h0645F350,32'h78C43CB9,32'hE0035766,32'h0EA016C6,32'h92571C3D,
    32'h96677D19,32'h9F20C2DB,32'hBC7F0E8D,32'hB1F027B4,32'h178977C3,
    32'h29DCB0D1,
    32'h58EEE22A,32'h915280DA,32'h6A333F1D,32'h292409A7,32'hF4CF55C8,
    32'h60BCE3A3,32'h2D7372C2,32'hE3033FA9,32'h50C1FAFE,
    32'h1FDF834A,32'h8E399D97,32'h7D11900C,32'hC5C8015F,
    32'hB3A98C46,
    32'h67D4643C,32'hAB3A1BAC,32'h95518E9E,32'h8E4CCA04,
    32'h96285AA9,32'h7E818F78,32'h20CDF565,32'hD2908C53,
    32'hD3958D73,32'h06EC1039,32'hD70F4CBA,32'hA9F2CE53,
    32'h1C237E84,32'hC1C4A2A0,32'h985B5C4D,32'hBD0ECB9E,
    32'h04F2443B,32'h880CA8A2,
    32'hBDF9B4EF,32'h66CEE4E9,32'h603E8D53,32'h0412A711,
    32'h7CA20791,
    32'h5DC3AA69,32'h3D9AD474,
    32'h1482D2A7,32'h0363E489,32'h24BE37F6,32'hA09E55E9,
    32'hDD3DE175,32'h6B2A1236,32'h9EF77DD5,32'h867C8969,
    32'hC7641A7E,
    32'hA7D33777,32'h041FDA59,
    32'h001B30E8,32'hA5950CFF,32'h5926FCC5,32'hF3D49D59,
    32'h25197B4E,
    32'h5C34F43D,
    32'h0936B7DF,32'h075AE096,32'h342A2416,32'h895DCF44,
    32'hFADDF41C,
    32'h8E027BD2,32'h1754E006,32'h3A35F804,32'hC039C251,
    32'h7FFB98B2,32'h9B132BD0,32'h5622E174,32'h206A8B68,
    32'hF1D441D8,
    32'h9A447668,32'hF22D0DAB,32'hEA684D09,
    32'hED3BB9E4,32'hAC824E15,
    32'h53A23D4D,32'h7E47C195,
    32'hB211DFED,32'h4E56C97A,32'h6B4A0009,
    32'h108DE0A5,
    32'hAE9A2682,32'h0AC328F5,
    32'h565C0FCD,32'hE546B793,
    32'h958D7E97,
    32'hE356E438,
    32'hDB93D097,
    32'h737CE3A9,
    32'h823DBD1F,
    32'hD7483CDA
  };

  function automatic logic [5:0] rom_fam(input logic [7:0] idx);
    logic [5:0] f;
    f = 6'd0;
    if      (idx < 8'd20)  f = 6'd1;
    else if (idx < 8'd21)  f = 6'd2;
    else if (idx < 8'd43)  f = 6'd3;
    else if (idx < 8'd44)  f = 6'd4;
    else if (idx < 8'd49)  f = 6'd5;
    else if (idx < 8'd61)  f = 6'd6;
    else if (idx < 8'd91)  f = 6'd7;
    else if (idx < 8'd102) f = 6'd8;
    else if (idx < 8'd107) f = 6'd9;
    else if (idx < 8'd116) f = 6'd10;
    else if (idx < 8'd120) f = 6'd11;
    else if (idx < 8'd132) f = 6'd12;
    else if (idx < 8'd134) f = 6'd13;
    else if (idx < 8'd139) f = 6'd14;
    else if (idx < 8'd141) f = 6'd15;
    else if (idx < 8'd145) f = 6'd16;
    else if (idx < 8'd147) f = 6'd17;
    else if (idx < 8'd148) f = 6'd18;
    else if (idx < 8'd149) f = 6'd19;
    else if (idx < 8'd150) f = 6'd20;
    else if (idx < 8'd152) f = 6'd21;
    else if (idx < 8'd156) f = 6'd22;
    else if (idx < 8'd157) f = 6'd23;
    else if (idx < 8'd158) f = 6'd24;
    else if (idx < 8'd162) f = 6'd25;
    else if (idx < 8'd163) f = 6'd26;
    else if (idx < 8'd164) f = 6'd27;
    else if (idx < 8'd166) f = 6'd28;
    else if (idx < 8'd167) f = 6'd29;
    else if (idx < 8'd169) f = 6'd30;
    else if (idx < 8'd170) f = 6'd31;
    else if (idx < 8'd171) f = 6'd32;
    else if (idx < 8'd172) f = 6'd33;
    else if (idx < 8'd175) f = 6'd34;
    else if (idx < 8'd177) f = 6'd35;
    else if (idx < 8'd179) f = 6'd36;
    else if (idx < 8'd182) f = 6'd37;
    else if (idx < 8'd183) f = 6'd38;
    else if (idx < 8'd185) f = 6'd39;
    else if (idx < 8'd187) f = 6'd40;
    else if (idx < 8'd193) f = 6'd41 + 6'(idx - 8'd187);
    return f;
  endfunction

  // Queue entry between the front end and the back end.
  typedef struct packed {
    logic       is_byte;
    logic [5:0] crc_fam;
    logic       crc_load;
    logic [7:0] data;
    logic       last;
  } job_t;

endpackage

[sv/lsi_front.sv]
// Front end: accepts transactions, walks the CRC table for start items, pushes jobs.
module lsi_front import lsi_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] crc_i,
  input  logic [7:0]  data_i,
  input  logic        last_i,
  output logic        push_o,
  output job_t        job_o,
  input  logic        full_i
);
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  logic            walk_q, walk_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     crc_q, crc_d;
  logic [5:0]      fam_q, fam_d;
  logic            last_q, last_d;
  logic            hit;
  logic            done;
  logic            acc;

  assign in_ready_o = !walk_q && !full_i;
  assign acc  = in_valid_i && in_ready_o;
  assign hit  = (crc_q != 32'd0) && (RomCrc[8'(idx_q)] == crc_q);
  assign done = walk_q && (32'(idx_q) == TableEntries - 1) && !full_i;

  always_comb begin
    walk_d = walk_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    fam_d  = fam_q;
    last_d = last_q;
    if (acc && cmd_e'(cmd_i) == CMD_START) begin
      walk_d = 1'b1;
      idx_d  = '0;
      crc_d  = crc_i;
      fam_d  = 6'd0;
      last_d = last_i;
    end else if (walk_q) begin
      if (hit) fam_d = rom_fam(8'(idx_q));
      if (32'(idx_q) == TableEntries - 1) begin
        if (!full_i) walk_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_comb begin
    push_o = 1'b0;
    job_o  = '0;
    if (done) begin
      push_o         = 1'b1;
      job_o.crc_load = 1'b1;
      job_o.crc_fam  = hit ? rom_fam(8'(idx_q)) : fam_q;
      job_o.last     = last_q;
    end else if (acc && cmd_e'(cmd_i) == CMD_BYTE) begin
      push_o        = 1'b1;
      job_o.is_byte = 1'b1;
      job_o.data    = data_i;
      job_o.last    = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      walk_q <= walk_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q  <= crc_d;
    fam_q  <= fam_d;
    last_q <= last_d;
  end
endmodule

[sv/lsi_fifo.sv]
// Short job queue between front end and back end.
module lsi_fifo import lsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t din_i,
  output logic full_o,
  input  logic pop_i,
  output job_t dout_o,
  output logic empty_o
);
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign dout_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

[sv/lsi_back.sv]
// Back end: signature scan over the byte window and result register.
module lsi_back import lsi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] scan_starts_i,
  input  logic       empty_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] id_o,
  output logic       by_crc_o
);
  logic [5:0]  crc_fam_q, crc_fam_d;
  logic [5:0]  scan_fam_q, scan_fam_d;
  logic [31:0] win_q, win_d;
  logic [7:0]  pos_q, pos_d;
  logic        ov_q;
  logic [5:0]  id_q;
  logic        bc_q;
  logic [39:0] w5;
  logic        en5, en4;

  assign pop_o = !empty_i && (!ov_q || out_ready_i);
  assign w5    = {win_q, job_i.data};
  assign en5   = (pos_q >= 8'd4) && ((pos_q - 8'd4) < scan_starts_i);
  assign en4   = (pos_q >= 8'd3) && ((pos_q - 8'd3) < scan_starts_i);

  always_comb begin
    crc_fam_d  = crc_fam_q;
    scan_fam_d = scan_fam_q;
    win_d      = win_q;
    pos_d      = pos_q;
    if (job_i.crc_load) begin
      crc_fam_d  = job_i.crc_fam;
      scan_fam_d = 6'd0;
      win_d      = 32'd0;
      pos_d      = 8'd0;
    end else if (job_i.is_byte) begin
      if (pos_q != 8'd255) begin
        if (en5) begin
          if (w5 == Sig5C) scan_fam_d = FamC;
          if (w5 == Sig5G) scan_fam_d = FamG;
          if (w5 == Sig5S) scan_fam_d = FamS;
        end
        if (en4 && (w5[31:0] == Sig4A || w5[31:0] == Sig4B)) scan_fam_d = FamN;
        pos_d = pos_q + 8'd1;
      end
      win_d = w5[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_fam_q  <= 6'd0;
      scan_fam_q <= 6'd0;
      win_q      <= 32'd0;
      pos_q      <= 8'd0;
      ov_q       <= 1'b0;
    end else begin
      if (pop_o) begin
        crc_fam_q  <= crc_fam_d;
        scan_fam_q <= scan_fam_d;
        win_q      <= win_d;
        pos_q      <= pos_d;
      end
      if (pop_o && job_i.last) ov_q <= 1'b1;
      else if (out_ready_i)   ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && job_i.last) begin
      bc_q <= (crc_fam_d != 6'd0);
      id_q <= (crc_fam_d != 6'd0) ? crc_fam_d : scan_fam_d;
    end
  end

  assign out_valid_o = ov_q;
  assign id_o        = id_q;
  assign by_crc_o    = bc_q;
endmodule

[sv/loader_signature_identifier.sv]
// Top level of the loader signature identifier.
// Usage:
//   s_axis carries one transaction per item. A start item (command 0) brings the
//   CRC of a first program; program bytes (command 1) follow. tlast marks the
//   item on which a result is produced.
//   m_axis carries one result transaction per item with tlast set.
//   cfg_we_i / cfg_wdata_i write scan_starts (reset 200); write only when idle.
// Data flow:
//   Program bytes are taken one per cycle while s_axis_tready is high; a byte with
//   tlast is written into the job queue when its transaction is accepted, the back
//   end pops it once the result register is free or being taken, and the result
//   register then presents it on m_axis. A start item walks the CRC table one entry
//   a cycle in the front end, during which s_axis_tready is low; its job enters the
//   queue when the walk reaches the last entry and the queue is not full.
// Reset:
//   The back-end families, window and position clear; no transaction is pending.
// Stall:
//   When m_axis_tready is low the result is held; the back end stops, the
//   two-entry queue fills, and then s_axis_tready drops.
module loader_signature_identifier import lsi_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // crc_value[31:0], data_byte[39:32]
  input  logic        s_axis_tuser,  // command
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // family_id[5:0], found_by_crc[6], zero fill
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  logic [7:0] scan_starts_q;
  logic       push, full, pop, empty;
  job_t       job_in, job_out;
  logic [5:0] id;
  logic       by_crc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scan_starts_q <= ScanStartsRst;
    else if (cfg_we_i) scan_starts_q <= cfg_wdata_i;
  end

  lsi_front #(.TableEntries(TableEntries)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser), .crc_i(s_axis_tdata[31:0]),
    .data_i(s_axis_tdata[39:32]), .last_i(s_axis_tlast),
    .push_o(push), .job_o(job_in), .full_i(full)
  );

  lsi_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .din_i(job_in), .full_o(full),
    .pop_i(pop), .dout_o(job_out), .empty_o(empty)
  );

  lsi_back u_back (
    .clk_i, .rst_ni, .scan_starts_i(scan_starts_q), .empty_i(empty),
    .job_i(job_out), .pop_o(pop), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .id_o(id), .by_crc_o(by_crc)
  );

  assign m_axis_tdata = {1'b0, by_crc, id};

  // Never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && full))
    else $error("push into full queue");
  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // A result found by CRC never carries family zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[5:0] != 6'd0)
    else $error("crc result with zero family");
endmodule

[sim/tb.sv]
// Loader signature identifier testbench: directed and random streams checked by a predictor.
module tb;
  import lsi_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;  // crc_value[31:0], data_byte[39:32]
  logic        s_axis_tuser;  // command
  logic        s_axis_tlast;  // last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;  // family_id[5:0], found_by_crc[6], zero fill
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;

  loader_signature_identifier dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i
  );

  // Scoreboard: tracks the identifier state and holds the results still owed.
  class result_board;
    logic [7:0]  starts_limit;
    logic [5:0]  crc_fam;
    logic [5:0]  scan_fam;
    logic [31:0] window;
    logic [7:0]  position;
    logic [7:0]  pending_ids[$];
    int          errors;
    int          checked;
    int          crc_hits;
    int          sig_hits;

    function void clear();
      starts_limit = ScanStartsRst;
      crc_fam = '0; scan_fam = '0; window = '0; position = '0;
      errors = 0; checked = 0; crc_hits = 0; sig_hits = 0;
    endfunction

    // Table family of entry idx, from the run lengths of the table.
    function logic [5:0] table_fam(int idx);
      int bounds[46];
      bounds = '{20,21,43,44,49,61,91,102,107,116,120,132,134,139,141,145,147,148,
                 149,150,152,156,157,158,162,163,164,166,167,169,170,171,172,175,
                 177,179,182,183,185,187,188,189,190,191,192,193};
      for (int f = 0; f < 46; f++) if (idx < bounds[f]) return 6'(f + 1);
      return '0;
    endfunction

    // Family of a CRC: the last matching table entry, a zero CRC never matches.
    function logic [5:0] crc_family_of(logic [31:0] crc);
      logic [5:0] fam;
      fam = '0;
      if (crc == '0) return '0;
      for (int i = 0; i < RomLen; i++) begin
        if (RomCrc[i] == crc) fam = table_fam(i);
      end
      return fam;
    endfunction

    function void note_item(logic cmd, logic [31:0] crc, logic [7:0] b, logic last);
      logic [39:0] w5;
      logic [31:0] w4;
      if (cmd == CMD_START) begin
        crc_fam = crc_family_of(crc);
        scan_fam = '0; window = '0; position = '0;
      end else begin
        w5 = {window, b};
        w4 = w5[31:0];
        if (position != 8'd255) begin
          if (position >= 4 && (position - 4) < starts_limit) begin
            if (w5 == Sig5C) scan_fam = FamC;
            if (w5 == Sig5G) scan_fam = FamG;
            if (w5 == Sig5S) scan_fam = FamS;
          end
          if (position >= 3 && (position - 3) < starts_limit)
            if (w4 == Sig4A || w4 == Sig4B) scan_fam = FamN;
          position++;
        end
        window = w4;
      end
      if (last) begin
        if (crc_fam != 0) begin
          pending_ids.push_back({1'b0, 1'b1, crc_fam}); crc_hits++;
        end else begin
          pending_ids.push_back({1'b0, 1'b0, scan_fam});
          if (scan_fam != 0) sig_hits++;
        end
      end
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (pending_ids.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual id %0d crc %0b",
                 $time, got[5:0], got[6]);
        errors++;
        return;
      end
      want = pending_ids.pop_front();
      checked++;
      if (got[5:0] != want[5:0]) begin
        $display("%0t: family id mismatch, expected %0d, actual %0d", $time, want[5:0], got[5:0]);
        errors++;
      end
      if (got[6] != want[6]) begin
        $display("%0t: found_by_crc mismatch, expected %0b, actual %0b", $time, want[6], got[6]);
        errors++;
      end
      if (got[7] != 1'b0) begin
        $display("%0t: tdata fill mismatch, expected 0, actual %0b", $time, got[7]);
        errors++;
      end
    endfunction
  endclass

  result_board board;
  int  items_sent;
  longint cycles;

  localparam longint CycleLimit = 2_000_000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drop the run if it hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, check each accepted transaction.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      if (m_axis_tvalid && m_axis_tready || !m_axis_tready) begin
        if (stall_left > 0) begin
          m_axis_tready <= 1'b0;
          stall_left    <= stall_left - 1;
        end else begin
          m_axis_tready <= 1'b1;
          // one time in four take the next result without a stall
          stall_left    <= (($urandom % 4) == 0) ? 0 : $urandom_range(0, 11);
        end
      end
    end
  end

  // Send one item and wait for its transaction; gap drawn per item.
  // tvalid stays high after the transaction so items can follow back to back.
  task automatic send_item(logic cmd, logic [31:0] crc, logic [7:0] b, logic last);
    int gap;
    gap = ($urandom % 3 == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    // unused field carries noise so every tdata bit toggles
    s_axis_tdata  <= {b, (cmd == CMD_START) ? crc : 32'($urandom)};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(cmd, crc, b, last);
    items_sent++;
  endtask

  task automatic send_start(logic [31:0] crc, logic last);
    send_item(CMD_START, crc, 8'($urandom), last);
  endtask

  task automatic send_bytes(logic [7:0] bytes[$], logic last);
    foreach (bytes[i]) send_item(CMD_BYTE, 32'($urandom), bytes[i], last && i == bytes.size() - 1);
  endtask

  // Idle the block, then write scan_starts.
  task automatic set_scan_starts(logic [7:0] v);
    s_axis_tvalid <= 1'b0;
    while (board.pending_ids.size() != 0) @(posedge clk_i);
    repeat (TableEntriesDef + 10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.starts_limit = v;
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_crc();
    case ($urandom % 4)
      0: return RomCrc[$urandom_range(0, RomLen - 1)];
      1: return '0;
      default: return $urandom;
    endcase
  endfunction

  // A signature drawn at random as a byte list.
  function automatic void pick_signature(ref logic [7:0] q[$]);
    logic [39:0] s;
    q = {};
    case ($urandom % 5)
      0: begin s = {8'h00, Sig4A}; for (int i = 3; i >= 0; i--) q.push_back(s[8*i +: 8]); end
      1: begin s = {8'h00, Sig4B}; for (int i = 3; i >= 0; i--) q.push_back(s[8*i +: 8]); end
      2: s = Sig5C;
      3: s = Sig5G;
      default: s = Sig5S;
    endcase
    if (q.size() == 0) for (int i = 4; i >= 0; i--) q.push_back(s[8*i +: 8]);
  endfunction

  // One program: optional start, random bytes with signatures planted, last on the final item.
  task automatic send_program(int max_len);
    logic [7:0] prog[$];
    logic [7:0] sig[$];
    int len;
    prog = {};
    len = $urandom_range(0, max_len);
    while (prog.size() < len) begin
      if ($urandom % 6 == 0) begin
        pick_signature(sig);
        // sometimes break the signature to test near misses
        if ($urandom % 4 == 0) sig[$urandom_range(0, sig.size() - 1)] ^= 8'(1 << ($urandom % 8));
        foreach (sig[i]) prog.push_back(sig[i]);
      end else begin
        prog.push_back(8'($urandom));
      end
    end
    if ($urandom % 10 != 0) send_start(pick_crc(), prog.size() == 0);
    if (prog.size() != 0) send_bytes(prog, 1'b1);
  endtask

  initial begin
    logic [7:0] q[$];
    board = new();
    board.clear();
    cycles = 0; items_sent = 0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = CMD_START; s_axis_tlast = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: table extremes, zero CRC, signatures (5G cut short), both 5-then-4 ordering.
    send_start(32'h261DBA0E, 1'b1);
    send_start(32'hD7483CDA, 1'b1);
    send_start(32'h00000000, 1'b1);
    send_start(32'hFFFFFFFF, 1'b0);
    send_bytes('{8'h0E, 8'h0F, 8'h16, 8'h01}, 1'b1);
    send_start('0, 1'b0);
    send_bytes('{8'h03, 8'h19, 8'h02, 8'h05, 8'h12}, 1'b1);
    send_bytes('{8'h53, 8'h4E, 8'h41, 8'h4B, 8'h45}, 1'b1);  // bytes without a start
    send_start('0, 1'b0);
    send_bytes('{8'h47, 8'h4F, 8'h20, 8'h41}, 1'b1);         // short program
    send_start('0, 1'b0);
    send_bytes('{8'h4E, 8'h4F, 8'h56, 8'h41, 8'h57}, 1'b1);

    // Scan limits at both extremes; long programs hit saturation.
    set_scan_starts(8'd0);
    send_program(12);
    set_scan_starts(8'd255);
    for (int r = 0; r < 2; r++) begin
      send_start('0, 1'b0);
      for (int i = 0; i < 262; i++) send_item(CMD_BYTE, '0, 8'($urandom), 1'b0);
      q = {};
      pick_signature(q);
      send_bytes(q, 1'b1);
    end

    while (items_sent < 1550) begin
      if ($urandom % 40 == 0) set_scan_starts(($urandom % 3 == 0) ? 8'($urandom) : 8'($urandom_range(0, 30)));
      if ($urandom % 12 == 0)
        send_item(1'($urandom), 32'($urandom), 8'($urandom), 1'($urandom));  // noise
      else send_program(30);
    end

    set_scan_starts(8'd200);
    send_program(20);
    s_axis_tvalid <= 1'b0;
    while (board.pending_ids.size() != 0) @(posedge clk_i);
    repeat (TableEntriesDef + 20) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results (%0d by CRC, %0d by signature).",
             items_sent, board.checked, board.crc_hits, board.sig_hits);
    if (board.errors == 0 && board.pending_ids.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
